@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL. Empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/ncr_pkg.sv @@
// ----------------------------------------------------------------------------
// ncr_pkg
// Shared constants and control types of the cube root block.
// ----------------------------------------------------------------------------
`default_nettype none
package ncr_pkg;
    localparam int OPERAND_W       = 32;
    localparam int ROOT_W          = 22;
    localparam int TOL_W           = 16;
    localparam int DIV_W           = 2 * OPERAND_W;
    localparam int NB_W            = $clog2(DIV_W + 1);
    localparam int MAX_ITER_DEF    = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam logic [TOL_W-1:0]     TOL_RESET = 16'd1;
    localparam logic [OPERAND_W-1:0] ITER_SAT  = 32'hFFFF_FFFF;
    localparam logic [OPERAND_W-1:0] ROOT_MAX  = 32'h003F_FFFF;
    // floor(v/3) == (v * RECIP3) >> 33 for every 32-bit v.
    localparam logic [OPERAND_W-1:0] RECIP3    = 32'hAAAA_AAAB;
    localparam int RECIP3_SHIFT    = 33;

    typedef struct packed {
        logic load;      // capture operand, seed the iterate
        logic zero_out;  // produce the result of a zero operand
        logic div1;      // start x*2^F / prev
        logic chk;       // evaluate the overflow test on the first quotient
        logic div2;      // start (q1*2^F) / prev
        logic mul_t;     // multiply the second quotient by the reciprocal of 3
        logic mul_r;     // multiply the iterate by the reciprocal of 3
        logic update;    // form the next iterate
        logic finish;    // register the result
    } t_cmd;

    typedef struct packed {
        logic x_zero;
        logic div_done;
        logic sat;
        logic conv;
    } t_stat;
endpackage
`default_nettype wire

@@ hdl/ncr_div.sv @@
// ----------------------------------------------------------------------------
// ncr_div
// Restoring divider, one quotient bit per cycle, with a preloaded remainder.
// ----------------------------------------------------------------------------
`default_nettype none
module ncr_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [ncr_pkg::NB_W-1:0]      i_nbits,
    input  wire logic [ncr_pkg::OPERAND_W-1:0] i_rem,
    input  wire logic [ncr_pkg::DIV_W-1:0]     i_dq,
    input  wire logic [ncr_pkg::OPERAND_W-1:0] i_divisor,
    output logic                              o_done,
    output logic [ncr_pkg::DIV_W-1:0]          o_quot
);
    import ncr_pkg::*;

    logic [NB_W-1:0]      r_cnt;
    logic [OPERAND_W-1:0] r_rem;
    logic [DIV_W-1:0]     r_dq;
    logic [OPERAND_W:0]   trial;
    logic                 fits;

    // The dividend bits enter from the top of the shift register.
    assign trial  = {r_rem, r_dq[DIV_W-1]};
    assign fits   = trial >= {1'b0, i_divisor};
    assign o_done = (r_cnt == NB_W'(1));
    assign o_quot = r_dq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_nbits;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - NB_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_dq  <= i_dq;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? OPERAND_W'(trial - {1'b0, i_divisor}) : OPERAND_W'(trial);
            r_dq  <= {r_dq[DIV_W-2:0], fits};
        end
    end
endmodule
`default_nettype wire

@@ hdl/ncr_dp.sv @@
// ----------------------------------------------------------------------------
// ncr_dp
// Datapath: iterate register, divider, reciprocal multiplier, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module ncr_dp #(
    parameter int FRAC_BITS = ncr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ncr_pkg::t_cmd                i_cmd,
    input  wire logic [ncr_pkg::OPERAND_W-1:0] i_operand,
    input  wire logic [ncr_pkg::TOL_W-1:0]     i_tolerance,
    output ncr_pkg::t_stat                    o_stat,
    output logic [ncr_pkg::ROOT_W-1:0]         o_root,
    output logic                              o_converged
);
    import ncr_pkg::*;

    logic [OPERAND_W-1:0] r_x;
    logic [OPERAND_W-1:0] r_prev;
    logic                 r_sat;
    logic [DIV_W-1:0]     r_prod_t;
    logic [DIV_W-1:0]     r_prod_r;
    logic [ROOT_W-1:0]    r_root;
    logic                 r_conv;

    logic                 div_start;
    logic [NB_W-1:0]      div_nbits;
    logic [OPERAND_W-1:0] div_rem;
    logic [DIV_W-1:0]     div_dq;
    logic                 div_done;
    logic [DIV_W-1:0]     quot;
    logic [DIV_W-1:0]     lim;
    logic [DIV_W-1:0]     qs;
    logic                 sat;
    logic [OPERAND_W-1:0] mul_a;
    logic [DIV_W-1:0]     prod;
    logic [OPERAND_W-1:0] t3;
    logic [OPERAND_W-1:0] r3;
    logic [OPERAND_W-1:0] three_r3;
    logic                 rem_two;
    logic [OPERAND_W:0]   sum;
    logic [OPERAND_W-1:0] n_next;
    logic [OPERAND_W-1:0] diff;
    logic                 conv;

    // Overflow test: the second quotient would be 2^32 or more.
    assign lim = DIV_W'({{OPERAND_W{1'b0}}, r_prev} << (OPERAND_W - FRAC_BITS));
    assign sat = quot >= lim;
    assign qs  = quot << FRAC_BITS;

    assign div_start = i_cmd.div1 | i_cmd.div2;
    assign div_nbits = i_cmd.div1 ? NB_W'(OPERAND_W + FRAC_BITS) : NB_W'(OPERAND_W);
    assign div_rem   = i_cmd.div1 ? '0 : qs[DIV_W-1:OPERAND_W];
    assign div_dq    = i_cmd.div1 ? {r_x, {OPERAND_W{1'b0}}}
                                  : {qs[OPERAND_W-1:0], {OPERAND_W{1'b0}}};

    ncr_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_nbits   (div_nbits),
        .i_rem     (div_rem),
        .i_dq      (div_dq),
        .i_divisor (r_prev),
        .o_done    (div_done),
        .o_quot    (quot)
    );

    assign mul_a = i_cmd.mul_t ? quot[OPERAND_W-1:0] : r_prev;
    assign prod  = {{OPERAND_W{1'b0}}, mul_a} * {{OPERAND_W{1'b0}}, RECIP3};

    // Next iterate: floor(2r/3) + floor(t/3), saturated at 32 bits.
    assign t3       = OPERAND_W'(r_prod_t >> RECIP3_SHIFT);
    assign r3       = OPERAND_W'(r_prod_r >> RECIP3_SHIFT);
    assign three_r3 = r3 + (r3 << 1);
    assign rem_two  = (r_prev - three_r3) == OPERAND_W'(2);
    assign sum      = {1'b0, r3 << 1} + {{OPERAND_W{1'b0}}, rem_two} + {1'b0, t3};
    assign n_next   = (r_sat || sum[OPERAND_W]) ? ITER_SAT : sum[OPERAND_W-1:0];
    assign diff     = (n_next >= r_prev) ? (n_next - r_prev) : (r_prev - n_next);
    assign conv     = diff <= OPERAND_W'(i_tolerance);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_operand;
            r_prev <= i_operand;
        end else if (i_cmd.update) begin
            r_prev <= n_next;
        end
        if (i_cmd.chk) begin
            r_sat <= sat;
        end
        if (i_cmd.mul_t) begin
            r_prod_t <= prod;
        end
        if (i_cmd.mul_r) begin
            r_prod_r <= prod;
        end
        if (i_cmd.zero_out) begin
            r_root <= '0;
            r_conv <= 1'b1;
        end else if (i_cmd.finish) begin
            r_root <= (n_next > ROOT_MAX) ? ROOT_MAX[ROOT_W-1:0] : n_next[ROOT_W-1:0];
            r_conv <= conv;
        end
    end

    assign o_stat.x_zero   = (i_operand == '0);
    assign o_stat.div_done = div_done;
    assign o_stat.sat      = sat;
    assign o_stat.conv     = conv;
    assign o_root          = r_root;
    assign o_converged     = r_conv;
endmodule
`default_nettype wire

@@ hdl/ncr_ctrl.sv @@
// ----------------------------------------------------------------------------
// ncr_ctrl
// Sequencer for the Newton steps: issues datapath commands, counts steps.
// ----------------------------------------------------------------------------
`default_nettype none
module ncr_ctrl #(
    parameter int MAX_ITER = ncr_pkg::MAX_ITER_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire ncr_pkg::t_stat i_stat,
    output ncr_pkg::t_cmd       o_cmd,
    output logic                busy,
    output logic                o_done
);
    import ncr_pkg::*;

    localparam int ITER_W = $clog2(MAX_ITER);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_INIT = 7'b0000010,
        S_DIV1 = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_DIV2 = 7'b0010000,
        S_MULT = 7'b0100000,
        S_UPD  = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic              r_done;
    t_cmd              cmd;
    logic              r_mul_second;
    logic              last;

    assign last = (r_iter == ITER_W'(MAX_ITER - 1));

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    cmd.load = 1'b1;
                    n_iter   = '0;
                    if (i_stat.x_zero) begin
                        cmd.zero_out = 1'b1;
                    end else begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                cmd.div1 = 1'b1;
                n_state  = S_DIV1;
            end
            S_DIV1: begin
                if (i_stat.div_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                cmd.chk = 1'b1;
                if (i_stat.sat) begin
                    n_state = S_UPD;
                end else begin
                    cmd.div2 = 1'b1;
                    n_state  = S_DIV2;
                end
            end
            S_DIV2: begin
                if (i_stat.div_done) begin
                    n_state = S_MULT;
                end
            end
            S_MULT: begin
                // Two multiplier passes: quotient first, then the iterate.
                if (!r_mul_second) begin
                    cmd.mul_t = 1'b1;
                end else begin
                    cmd.mul_r = 1'b1;
                    n_state   = S_UPD;
                end
            end
            S_UPD: begin
                cmd.update = 1'b1;
                if (i_stat.conv || last) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_iter  = r_iter + ITER_W'(1);
                    n_state = S_INIT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_iter       <= '0;
            r_done       <= 1'b0;
            r_mul_second <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_iter       <= n_iter;
            r_done       <= cmd.finish | cmd.zero_out;
            r_mul_second <= cmd.mul_t;
        end
    end

    assign o_cmd  = cmd;
    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
endmodule
`default_nettype wire

@@ hdl/newton_cube_root.sv @@
// ----------------------------------------------------------------------------
// newton_cube_root
// Fixed-point cube root by Newton iteration with a settable tolerance.
// ----------------------------------------------------------------------------
// An item is taken when start is high while busy is low. Its result appears on
// o_root and o_converged for exactly one cycle, flagged by o_done, and the
// receiver cannot stall it, so it must capture the result in that cycle.
// A zero operand returns root 0 with converged set in the cycle after it is
// taken. Any other operand runs Newton steps until the change between two
// iterates is within the tolerance register or MAX_ITER steps have run.
// Each step is paced by the one-bit-per-cycle divider, which forms two
// quotients per step; a step whose first quotient overflows forms only the
// first quotient and skips the multiplier passes.
// For a nonzero operand, busy stays high for the whole item and drops in the
// cycle the result is shown, so a new item may start right then.
// The tolerance register (reset 1) is written through i_cfg_valid and
// i_cfg_data; o_cfg_ready is always high. Write it only while the block is
// idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module newton_cube_root #(
    parameter int MAX_ITER  = ncr_pkg::MAX_ITER_DEF,
    parameter int FRAC_BITS = ncr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [ncr_pkg::OPERAND_W-1:0] i_operand,
    output logic                              o_done,
    output logic [ncr_pkg::ROOT_W-1:0]         o_root,
    output logic                              o_converged,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [ncr_pkg::TOL_W-1:0]     i_cfg_data
);
    import ncr_pkg::*;

    logic [TOL_W-1:0] r_tolerance;
    t_cmd             cmd;
    t_stat            stat;

    // The tolerance register accepts a write in any cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= TOL_RESET;
        end else if (i_cfg_valid) begin
            r_tolerance <= i_cfg_data;
        end
    end

    ncr_ctrl #(
        .MAX_ITER (MAX_ITER)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    ncr_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_operand   (i_operand),
        .i_tolerance (r_tolerance),
        .o_stat      (stat),
        .o_root      (o_root),
        .o_converged (o_converged)
    );

    // A nonzero operand keeps the block busy in the following cycle.
    `ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, start && !busy && (i_operand != '0), busy)
    // A zero operand answers straight from idle with root 0 and converged set.
    `ASSERT_NEXT(a_zero_result, i_clk, i_rst_n, start && !busy && (i_operand == '0), o_done && (o_root == '0) && o_converged)
    // A result only follows work in the previous cycle.
    `ASSERT_IMPLIES(a_done_has_cause, i_clk, i_rst_n, o_done, $past(busy) || $past(start))
endmodule
`default_nettype wire
